FILE: rtl/isc_pkg.sv
// ============================================================================
// isc_pkg: shared types and constants for the IMU sample conditioner
// Register indexes, stream widths, divider constants, controller interface.
// ============================================================================
package isc_pkg;

    localparam int unsigned S_TDATA_W = 120;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 120;
    localparam int unsigned M_TUSER_W = 1;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFS_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFS_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFS_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THERM_COEF  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOUNT       = 3'd7;

    // mount modes
    localparam logic [2:0] MOUNT_YAW90    = 3'd1;
    localparam logic [2:0] MOUNT_YAW180   = 3'd2;
    localparam logic [2:0] MOUNT_YAW270   = 3'd3;
    localparam logic [2:0] MOUNT_PITCH_P  = 3'd4;
    localparam logic [2:0] MOUNT_PITCH_N  = 3'd5;
    localparam logic [2:0] MOUNT_ROLL90   = 3'd6;

    // (10*t + TEMP_BIAS) * c / 3400000, with 3400000 = 64 * 53125
    localparam logic [19:0] TEMP_BIAS     = 20'd39202;
    localparam int unsigned DIV_PRE_SHIFT = 6;
    // ceil(2^44 / 53125), exact for 28-bit dividends
    localparam logic [28:0] RECIP_53125   = 29'd331147032;
    localparam int unsigned RECIP_SHIFT   = 44;
    // ceil(2^19 / 10), exact for 16-bit dividends
    localparam logic [15:0] RECIP_10      = 16'd52429;
    localparam int unsigned RECIP10_SHIFT = 19;

    localparam logic [7:0] ERR_RUN_LIMIT     = 8'd5;
    localparam logic [7:0] INVALID_RUN_LIMIT = 8'd5;
    localparam logic [7:0] RUN_MAX           = 8'd255;

    typedef struct packed {
        logic load_in;   // capture input item
        logic mul1;      // temperature * coefficient
        logic mul2;      // reciprocal divide
        logic mul3;      // 9/10 and 8/10 scaling
        logic commit;    // finish item, update status, fill output register
    } isc_cmd_t;

    typedef struct packed {
        logic out_busy;  // output register holds an item not yet taken
    } isc_sts_t;

endpackage

FILE: rtl/isc_ctrl.sv
// ============================================================================
// isc_ctrl: sequencing controller
// Steps one item through the three multiply stages and the commit step.
// ============================================================================
module isc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  isc_pkg::isc_sts_t  sts,
    output isc_pkg::isc_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_MUL3 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait here while the output register is still occupied
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    s_ready    = 1'b1;
                    if (s_valid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_MUL1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/isc_datapath.sv
// ============================================================================
// isc_datapath: bias, thermal correction, rotation, bus health state
// Holds config registers, the staged correction divider and the output register.
// ============================================================================
module isc_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  isc_pkg::isc_cmd_t                   cmd,
    output isc_pkg::isc_sts_t                   sts,
    input  logic [isc_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [isc_pkg::S_TUSER_W-1:0]       s_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [isc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [isc_pkg::M_TUSER_W-1:0]       m_tuser
);

    // ---------------- configuration ----------------
    logic [15:0] aofs_x_reg, aofs_y_reg, aofs_z_reg;
    logic [15:0] gofs_x_reg, gofs_y_reg, gofs_z_reg;
    logic [15:0] coef_reg;
    logic [2:0]  mount_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aofs_x_reg <= '0;
            aofs_y_reg <= '0;
            aofs_z_reg <= '0;
            gofs_x_reg <= '0;
            gofs_y_reg <= '0;
            gofs_z_reg <= '0;
            coef_reg   <= '0;
            mount_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                isc_pkg::REG_ACCEL_OFS_X: aofs_x_reg <= cfg_data;
                isc_pkg::REG_ACCEL_OFS_Y: aofs_y_reg <= cfg_data;
                isc_pkg::REG_ACCEL_OFS_Z: aofs_z_reg <= cfg_data;
                isc_pkg::REG_GYRO_OFS_X:  gofs_x_reg <= cfg_data;
                isc_pkg::REG_GYRO_OFS_Y:  gofs_y_reg <= cfg_data;
                isc_pkg::REG_GYRO_OFS_Z:  gofs_z_reg <= cfg_data;
                isc_pkg::REG_THERM_COEF:  coef_reg   <= cfg_data;
                isc_pkg::REG_MOUNT:       mount_reg  <= cfg_data[2:0];
                default:                  mount_reg  <= mount_reg;
            endcase
        end
    end

    // ---------------- input capture ----------------
    logic [15:0] in_ax_reg, in_ay_reg, in_az_reg, in_temp_reg;
    logic [15:0] in_gx_reg, in_gy_reg, in_gz_reg;
    logic        in_nak_reg, in_short_reg, in_fin_reg, in_succ_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_nak_reg   <= s_tuser[0];
            in_short_reg <= s_tuser[1];
            in_ax_reg    <= s_tdata[15:0];
            in_ay_reg    <= s_tdata[31:16];
            in_az_reg    <= s_tdata[47:32];
            in_temp_reg  <= s_tdata[63:48];
            in_gx_reg    <= s_tdata[79:64];
            in_gy_reg    <= s_tdata[95:80];
            in_gz_reg    <= s_tdata[111:96];
            in_fin_reg   <= s_tdata[112];
            in_succ_reg  <= s_tdata[113];
        end
    end

    // ---------------- thermal correction, stage 1 ----------------
    // p = (10*t + 39202) * c, kept as sign and magnitude
    logic signed [19:0] temp_sx;
    logic signed [19:0] temp_scaled;
    logic signed [36:0] prod;
    logic [33:0]        prod_mag_reg;
    logic               prod_neg_reg;

    assign temp_sx     = 20'(signed'(in_temp_reg));
    assign temp_scaled = (temp_sx <<< 3) + (temp_sx <<< 1) + signed'(isc_pkg::TEMP_BIAS);
    assign prod        = 37'(temp_scaled) * 37'(signed'(coef_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            prod_neg_reg <= prod[36];
            prod_mag_reg <= prod[36] ? 34'(-prod) : prod[33:0];
        end
    end

    // ---------------- stage 2: divide by 3400000 ----------------
    logic [56:0] quot_full;
    logic [11:0] corr_mag_reg;

    assign quot_full = 57'(prod_mag_reg[33:isc_pkg::DIV_PRE_SHIFT]) * 57'(isc_pkg::RECIP_53125);

    always_ff @(posedge clk)
    begin
        if (cmd.mul2)
        begin
            corr_mag_reg <= quot_full[isc_pkg::RECIP_SHIFT +: 12];
        end
    end

    // ---------------- stage 3: 9/10 and 8/10 ----------------
    logic [14:0] corr9;
    logic [14:0] corr8;
    logic [30:0] y_full;
    logic [30:0] z_full;
    logic [11:0] corr_y_mag_reg;
    logic [11:0] corr_z_mag_reg;

    assign corr9  = (15'(corr_mag_reg) << 3) + 15'(corr_mag_reg);
    assign corr8  = 15'(corr_mag_reg) << 3;
    assign y_full = 31'(corr9) * 31'(isc_pkg::RECIP_10);
    assign z_full = 31'(corr8) * 31'(isc_pkg::RECIP_10);

    always_ff @(posedge clk)
    begin
        if (cmd.mul3)
        begin
            corr_y_mag_reg <= y_full[isc_pkg::RECIP10_SHIFT +: 12];
            corr_z_mag_reg <= z_full[isc_pkg::RECIP10_SHIFT +: 12];
        end
    end

    // ---------------- commit: bias, correction, rotation ----------------
    logic [15:0] corr_x16, corr_y16, corr_z16;
    logic [15:0] bx, by, bz;
    logic [15:0] gx, gy, gz;
    logic [15:0] rx, ry, rz;

    assign corr_x16 = prod_neg_reg ? 16'(-{4'b0, corr_mag_reg})   : {4'b0, corr_mag_reg};
    assign corr_y16 = prod_neg_reg ? 16'(-{4'b0, corr_y_mag_reg}) : {4'b0, corr_y_mag_reg};
    assign corr_z16 = prod_neg_reg ? 16'(-{4'b0, corr_z_mag_reg}) : {4'b0, corr_z_mag_reg};

    assign bx = in_ax_reg - aofs_x_reg;
    assign by = in_ay_reg - aofs_y_reg;
    assign bz = in_az_reg - aofs_z_reg;
    assign gx = in_gx_reg - gofs_x_reg + corr_x16;
    assign gy = in_gy_reg - gofs_y_reg + corr_y16;
    assign gz = in_gz_reg - gofs_z_reg + corr_z16;

    always_comb
    begin
        rx = bx;
        ry = by;
        rz = bz;
        case (mount_reg)
            isc_pkg::MOUNT_YAW90:
            begin
                rx = by;
                ry = -bx;
            end
            isc_pkg::MOUNT_YAW180:
            begin
                rx = -bx;
                ry = -by;
            end
            isc_pkg::MOUNT_YAW270:
            begin
                rx = -by;
                ry = bx;
            end
            isc_pkg::MOUNT_PITCH_P:
            begin
                rx = by;
                ry = -bz;
                rz = bx;
            end
            isc_pkg::MOUNT_PITCH_N:
            begin
                rx = by;
                ry = bz;
                rz = -bx;
            end
            isc_pkg::MOUNT_ROLL90:
            begin
                rx = bz;
                ry = by;
                rz = -bx;
            end
            default:
            begin
                rx = bx;
            end
        endcase
    end

    // ---------------- bus health state ----------------
    logic [7:0] err_run_reg, err_run_next;
    logic [7:0] inv_run_reg, inv_run_next;
    logic       busy_reg, busy_next;
    logic       degr_reg, degr_next;
    logic       dpend_reg, dpend_next;
    logic       dout_reg, dout_next;
    logic       request;
    logic       sample_ok;

    assign sample_ok = !in_nak_reg && !in_short_reg;

    always_comb
    begin
        err_run_next = err_run_reg;
        inv_run_next = inv_run_reg;
        busy_next    = busy_reg;
        degr_next    = degr_reg;
        dpend_next   = dpend_reg;
        dout_next    = dout_reg;
        request      = 1'b0;

        // recovery-done event is latched first; success clears the error run
        if (in_fin_reg)
        begin
            dpend_next = 1'b1;
            dout_next  = in_succ_reg;
            if (in_succ_reg)
            begin
                err_run_next = '0;
            end
        end

        if (in_nak_reg)
        begin
            if (err_run_next != isc_pkg::RUN_MAX)
            begin
                err_run_next = err_run_next + 8'd1;
            end
            if (err_run_next > isc_pkg::ERR_RUN_LIMIT && !busy_next)
            begin
                request   = 1'b1;
                busy_next = 1'b1;
            end
        end
        else
        begin
            err_run_next = '0;
        end

        if (!sample_ok)
        begin
            if (!busy_next)
            begin
                if (inv_run_next != isc_pkg::RUN_MAX)
                begin
                    inv_run_next = inv_run_next + 8'd1;
                end
                if (inv_run_next >= isc_pkg::INVALID_RUN_LIMIT)
                begin
                    degr_next = 1'b1;
                end
            end
        end
        else
        begin
            inv_run_next = '0;
            degr_next    = 1'b0;
            if (dpend_next)
            begin
                degr_next  = !dout_next;
                busy_next  = 1'b0;
                dpend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_run_reg <= '0;
            inv_run_reg <= '0;
            busy_reg    <= 1'b0;
            degr_reg    <= 1'b0;
            dpend_reg   <= 1'b0;
            dout_reg    <= 1'b0;
        end
        else if (cmd.commit)
        begin
            err_run_reg <= err_run_next;
            inv_run_reg <= inv_run_next;
            busy_reg    <= busy_next;
            degr_reg    <= degr_next;
            dpend_reg   <= dpend_next;
            dout_reg    <= dout_next;
        end
    end

    // ---------------- output register ----------------
    logic                          m_valid_reg;
    logic [isc_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_ok_reg <= sample_ok;
            if (sample_ok)
            begin
                m_data_reg[111:0] <= {gz, gy, gx, in_temp_reg, rz, ry, rx};
            end
            else
            begin
                m_data_reg[111:0] <= '0;
            end
            m_data_reg[112]     <= degr_next;
            m_data_reg[113]     <= request;
            m_data_reg[114]     <= busy_next;
            m_data_reg[119:115] <= '0;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;
    assign m_tuser      = m_ok_reg;
    assign sts.out_busy = m_valid_reg && !m_tready;

endmodule

FILE: rtl/imu_sample_conditioner.sv
// ============================================================================
// imu_sample_conditioner: six-axis IMU read conditioning
// Bias removal, thermal gyro correction, accel mount rotation, bus health.
// ============================================================================
// Sequence: from input accept to m_axis_tvalid the item passes the coefficient product,
//   reciprocal divide, 9/10 and 8/10 scaling and the commit into the output register.
// Flow: one item is in work at a time; the next item is taken while idle or in the commit
//   cycle, after the staged correction multiplies; a held result stalls the commit.
// Reset: rst_n asynchronous, active low; clears config registers, run counters,
//   recovery and degraded flags, controller state and output valid.
module imu_sample_conditioner
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input item stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] raw_accel_x, [31:16] raw_accel_y, [47:32] raw_accel_z,
    // [63:48] raw_temperature, [79:64] raw_gyro_x, [95:80] raw_gyro_y,
    // [111:96] raw_gyro_z, [112] recovery_finished, [113] recovery_succeeded,
    // [119:114] zero pad
    input  logic [isc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] address_nak, [1] short_read
    input  logic [isc_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] temperature,
    // [79:64] gyro_x, [95:80] gyro_y, [111:96] gyro_z, [112] degraded,
    // [113] recovery_request, [114] recovery_active, [119:115] zero pad
    output logic [isc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [0] sample_ok
    output logic [isc_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    // configuration writes: 0-2 accel offsets, 3-5 gyro offsets,
    // 6 thermal coefficient, 7 mount orientation (data[2:0])
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [isc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // controller <-> datapath
    isc_pkg::isc_cmd_t cmd;
    isc_pkg::isc_sts_t sts;

    // controller: idle -> mul1 -> mul2 -> mul3 -> fin; fin holds while
    // the output register is full and not taken, and takes the next item when it commits
    isc_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: config registers, divider stages, health state, output reg
    isc_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser)
    );

endmodule

FILE: rtl/isc_checker.sv
// ============================================================================
// isc_checker: port-level assertions for the IMU sample conditioner
// Watches the result stream only; attached to the top level by bind.
// ============================================================================
module isc_props
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [isc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic [isc_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    // stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a failed read carries zero sample fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[111:0] == '0)
        else $error("invalid item with nonzero sample data");

    // a recovery request always leaves recovery marked active
    a_req_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[113] |-> m_axis_tdata[114])
        else $error("recovery request without recovery active");

    // requests only come from address failures, never from a good sample
    a_req_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[113])
        else $error("recovery request on a valid sample");

endmodule

bind imu_sample_conditioner isc_props u_isc_props
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
